/* src/srtf_pkg.sv */
// Shared codes, widths and control types of the SRTF scheduler.
package srtf_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned IN_T_W  = 16;
  localparam int unsigned OUT_T_W = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned JC_W    = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Register map
  localparam logic CFG_JOB_COUNT = 1'b0;
  localparam logic [JC_W-1:0] JOB_COUNT_RESET = 5'd1;

  // Job table strobes from the sequencer
  typedef struct packed {
    logic rd_en;     // read all fields at rd_addr
    logic ld_we;     // write arrival and burst at wr_addr
    logic rem_we;    // write remaining at wr_addr
    logic done_set;  // mark wr_addr done
    logic done_clr;  // unmark wr_addr
    logic clr_all;   // unmark every slot
  } tbl_ctl_t;

endpackage

/* src/srtf_table.sv */
// Job table: arrival, burst and remaining memories plus done flags.
module srtf_table #(
  parameter int unsigned MAX_JOBS  = 16,
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned IW        = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srtf_pkg::tbl_ctl_t   ctl_i,
  input  logic [IW-1:0]        rd_addr_i,
  input  logic [IW-1:0]        wr_addr_i,
  input  logic [TIME_BITS-1:0] ld_arr_i,
  input  logic [TIME_BITS-1:0] ld_bur_i,
  input  logic [TIME_BITS-1:0] rem_wdata_i,
  output logic [TIME_BITS-1:0] rd_arr_o,
  output logic [TIME_BITS-1:0] rd_bur_o,
  output logic [TIME_BITS-1:0] rd_rem_o,
  output logic                 rd_done_o
);
  import srtf_pkg::*;

  logic [TIME_BITS-1:0] arr_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] bur_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] rem_mem [MAX_JOBS];
  logic [MAX_JOBS-1:0]  done_q;

  // Memories: one write port each, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_we) begin
      arr_mem[wr_addr_i] <= ld_arr_i;
      bur_mem[wr_addr_i] <= ld_bur_i;
    end
    if (ctl_i.rem_we) begin
      rem_mem[wr_addr_i] <= rem_wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_arr_o  <= arr_mem[rd_addr_i];
      rd_bur_o  <= bur_mem[rd_addr_i];
      rd_rem_o  <= rem_mem[rd_addr_i];
      rd_done_o <= done_q[rd_addr_i];
    end
  end

  // Done flags, cleared by reset and by a clear command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (ctl_i.clr_all) begin
      done_q <= '0;
    end else if (ctl_i.done_set) begin
      done_q[wr_addr_i] <= 1'b1;
    end else if (ctl_i.done_clr) begin
      done_q[wr_addr_i] <= 1'b0;
    end
  end

endmodule

/* src/srtf_cmp.sv */
// Shared compare unit: does the candidate job beat the current best?
module srtf_cmp #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 elig_i,
  input  logic                 have_best_i,
  input  logic [TIME_BITS-1:0] cand_rem_i,
  input  logic [TIME_BITS-1:0] cand_arr_i,
  input  logic [TIME_BITS-1:0] best_rem_i,
  input  logic [TIME_BITS-1:0] best_arr_i,
  output logic                 take_o
);
  import srtf_pkg::*;

  logic shorter;
  logic tie_earlier;

  // Least remaining wins, earlier arrival breaks a tie, lower slot keeps it
  assign shorter     = cand_rem_i < best_rem_i;
  assign tie_earlier = (cand_rem_i == best_rem_i) && (cand_arr_i < best_arr_i);
  assign take_o      = elig_i && (!have_best_i || shorter || tie_earlier);

endmodule

/* src/srtf_scheduler.sv */
// Top level of the SRTF scheduler: APB register, command sequencer, result.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------------
//  command   | start & !busy                    | command, slot, arrival, burst
//  result    | done_o (one cycle, no stall)     | ran/finish fields, totals, all_done
//  config    | psel & penable & pwrite & pready | job_count at byte address 0
//
//  A tick scans the n slots in use, serves the best pending job one unit in ST_UPD_A,
//  adds ST_UPD_B..D when a job finishes and ends in ST_DONE; the scan reads one slot
//  per cycle through the compare unit. A clear first sweeps all MAX_JOBS slots
//  reloading remaining, a load to a valid slot writes it in ST_LOAD; both then scan to settle all_done.
//  busy is high from the accepted transaction through the result cycle.
//  Reset clears time, totals and done flags; job_count returns to 1.
module srtf_scheduler #(
  parameter int unsigned MAX_JOBS  = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [srtf_pkg::CMD_W-1:0]    command_i,
  input  logic [srtf_pkg::SLOT_W-1:0]   slot_i,
  input  logic [srtf_pkg::IN_T_W-1:0]   arrival_time_i,
  input  logic [srtf_pkg::IN_T_W-1:0]   burst_time_i,
  // result
  output logic                          done_o,
  output logic                          ran_valid_o,
  output logic [srtf_pkg::SLOT_W-1:0]   ran_slot_o,
  output logic [srtf_pkg::OUT_T_W-1:0]  time_now_o,
  output logic                          finished_o,
  output logic [srtf_pkg::OUT_T_W-1:0]  finish_time_o,
  output logic [srtf_pkg::OUT_T_W-1:0]  turnaround_o,
  output logic [srtf_pkg::OUT_T_W-1:0]  waiting_o,
  output logic [srtf_pkg::SUM_W-1:0]    sum_turnaround_o,
  output logic [srtf_pkg::SUM_W-1:0]    sum_waiting_o,
  output logic                          all_done_o
);
  import srtf_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned NW = (CW > JC_W) ? CW : JC_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_JOBS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SWEEP, ST_SCAN,
    ST_UPD_A, ST_UPD_B, ST_UPD_C, ST_UPD_D, ST_DONE
  } state_e;

  state_e               state_q;
  logic [JC_W-1:0]      job_count_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [IW-1:0]        slot_idx_q;
  logic [TIME_BITS-1:0] ld_arr_q;
  logic [TIME_BITS-1:0] ld_bur_q;
  logic [NW-1:0]        cnt_q;
  logic                 s1_vld_q;
  logic [IW-1:0]        s1_idx_q;
  logic                 found_q;
  logic [IW-1:0]        best_idx_q;
  logic [TIME_BITS-1:0] best_rem_q;
  logic [TIME_BITS-1:0] best_arr_q;
  logic [TIME_BITS-1:0] best_bur_q;
  logic                 pend_any_q;
  logic                 pend_many_q;
  logic [OUT_T_W-1:0]   time_q;
  logic [OUT_T_W-1:0]   turn_q;
  logic [OUT_T_W-1:0]   wait_q;
  logic [SUM_W-1:0]     sum_turn_q;
  logic [SUM_W-1:0]     sum_wait_q;
  logic                 rv_q;
  logic                 fin_q;
  logic                 all_done_q;

  logic                 accept;
  logic                 cfg_wr;
  logic [NW-1:0]        jc_ext;
  logic [NW-1:0]        n_use;
  logic [NW-1:0]        limit;
  logic                 slot_ok;
  logic [TIME_BITS-1:0] in_arr;
  logic [TIME_BITS-1:0] in_bur;
  logic                 best_last;
  logic                 scan_elig;
  logic                 take;
  tbl_ctl_t             ctl;
  logic [IW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] rem_wdata;
  logic [TIME_BITS-1:0] rd_arr;
  logic [TIME_BITS-1:0] rd_bur;
  logic [TIME_BITS-1:0] rd_rem;
  logic                 rd_done;

  // Handshakes and configuration
  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == CFG_JOB_COUNT) ? 32'(job_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q <= JOB_COUNT_RESET;
    end else if (cfg_wr && (paddr[2] == CFG_JOB_COUNT)) begin
      job_count_q <= pwdata[JC_W-1:0];
    end
  end

  // Slots in use, saturated at the table size
  assign jc_ext = NW'(job_count_q);
  assign n_use  = (jc_ext > MAX_N) ? MAX_N : jc_ext;
  assign limit  = (state_q == ST_SWEEP) ? MAX_N : n_use;

  // Incoming load fields, trimmed to the time width; zero burst means one
  assign slot_ok = 32'(slot_i) < MAX_JOBS;
  assign in_arr  = TIME_BITS'(arrival_time_i);
  assign in_bur  = (TIME_BITS'(burst_time_i) == '0) ? TIME_BITS'(1)
                                                     : TIME_BITS'(burst_time_i);

  // Best job has its last unit left
  assign best_last = best_rem_q <= TIME_BITS'(1);

  // Scan candidate: not done and already arrived
  assign scan_elig = !rd_done && (OUT_T_W'(rd_arr) <= time_q);

  srtf_cmp #(
    .TIME_BITS(TIME_BITS)
  ) u_cmp (
    .elig_i     (scan_elig),
    .have_best_i(found_q),
    .cand_rem_i (rd_rem),
    .cand_arr_i (rd_arr),
    .best_rem_i (best_rem_q),
    .best_arr_i (best_arr_q),
    .take_o     (take)
  );

  // Table control
  always_comb begin
    ctl          = '0;
    ctl.rd_en    = ((state_q == ST_SWEEP) || (state_q == ST_SCAN)) && (cnt_q != limit);
    ctl.clr_all  = accept && (command_i == CMD_CLEAR);
    wr_addr      = best_idx_q;
    rem_wdata    = best_last ? '0 : best_rem_q - TIME_BITS'(1);
    unique case (state_q)
      ST_LOAD: begin
        ctl.ld_we    = 1'b1;
        ctl.rem_we   = 1'b1;
        ctl.done_clr = 1'b1;
        wr_addr      = slot_idx_q;
        rem_wdata    = ld_bur_q;
      end
      ST_SWEEP: begin
        ctl.rem_we = s1_vld_q;
        wr_addr    = s1_idx_q;
        rem_wdata  = rd_bur;
      end
      ST_UPD_A: begin
        ctl.rem_we   = found_q;
        ctl.done_set = found_q && best_last;
      end
      default: begin
      end
    endcase
  end

  srtf_table #(
    .MAX_JOBS (MAX_JOBS),
    .TIME_BITS(TIME_BITS),
    .IW       (IW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_addr_i  (cnt_q[IW-1:0]),
    .wr_addr_i  (wr_addr),
    .ld_arr_i   (ld_arr_q),
    .ld_bur_i   (ld_bur_q),
    .rem_wdata_i(rem_wdata),
    .rd_arr_o   (rd_arr),
    .rd_bur_o   (rd_bur),
    .rd_rem_o   (rd_rem),
    .rd_done_o  (rd_done)
  );

  // Sequencer, run state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_NOP;
      slot_idx_q  <= '0;
      ld_arr_q    <= '0;
      ld_bur_q    <= '0;
      cnt_q       <= '0;
      s1_vld_q    <= 1'b0;
      s1_idx_q    <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_rem_q  <= '0;
      best_arr_q  <= '0;
      best_bur_q  <= '0;
      pend_any_q  <= 1'b0;
      pend_many_q <= 1'b0;
      time_q      <= '0;
      turn_q      <= '0;
      wait_q      <= '0;
      sum_turn_q  <= '0;
      sum_wait_q  <= '0;
      rv_q        <= 1'b0;
      fin_q       <= 1'b0;
      all_done_q  <= 1'b0;
    end else begin
      s1_vld_q <= ctl.rd_en;
      s1_idx_q <= cnt_q[IW-1:0];
      if (ctl.rd_en) begin
        cnt_q <= cnt_q + NW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q       <= command_i;
            slot_idx_q  <= IW'(slot_i);
            ld_arr_q    <= in_arr;
            ld_bur_q    <= in_bur;
            cnt_q       <= '0;
            found_q     <= 1'b0;
            best_idx_q  <= '0;
            pend_any_q  <= 1'b0;
            pend_many_q <= 1'b0;
            turn_q      <= '0;
            wait_q      <= '0;
            rv_q        <= 1'b0;
            fin_q       <= 1'b0;
            unique case (command_i)
              CMD_CLEAR: begin
                time_q     <= '0;
                sum_turn_q <= '0;
                sum_wait_q <= '0;
                state_q    <= ST_SWEEP;
              end
              CMD_LOAD: state_q <= slot_ok ? ST_LOAD : ST_SCAN;
              default:  state_q <= ST_SCAN;
            endcase
          end
        end
        ST_LOAD: begin
          state_q <= ST_SCAN;
        end
        ST_SWEEP: begin
          // remaining reloads from burst, written in the cycle after its read
          if ((cnt_q == limit) && !s1_vld_q) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (s1_vld_q) begin
            if (!rd_done) begin
              pend_many_q <= pend_any_q;
              pend_any_q  <= 1'b1;
            end
            if (take) begin
              found_q    <= 1'b1;
              best_idx_q <= s1_idx_q;
              best_rem_q <= rd_rem;
              best_arr_q <= rd_arr;
              best_bur_q <= rd_bur;
            end
          end else if (cnt_q == limit) begin
            all_done_q <= !pend_any_q;
            if ((cmd_q == CMD_TICK) && pend_any_q) begin
              state_q <= ST_UPD_A;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_UPD_A: begin
          // serve one unit; the job completes on its last unit
          time_q     <= time_q + OUT_T_W'(1);
          rv_q       <= found_q;
          fin_q      <= found_q && best_last;
          all_done_q <= found_q && best_last && !pend_many_q;
          state_q    <= (found_q && best_last) ? ST_UPD_B : ST_DONE;
        end
        ST_UPD_B: begin
          turn_q  <= time_q - OUT_T_W'(best_arr_q);
          state_q <= ST_UPD_C;
        end
        ST_UPD_C: begin
          wait_q     <= turn_q - OUT_T_W'(best_bur_q);
          sum_turn_q <= sum_turn_q + SUM_W'(turn_q);
          state_q    <= ST_UPD_D;
        end
        ST_UPD_D: begin
          sum_wait_q <= sum_wait_q + SUM_W'(wait_q);
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result fields
  assign done_o           = (state_q == ST_DONE);
  assign ran_valid_o      = rv_q;
  assign ran_slot_o       = rv_q ? SLOT_W'(best_idx_q) : '0;
  assign time_now_o       = time_q;
  assign finished_o       = fin_q;
  assign finish_time_o    = fin_q ? time_q : '0;
  assign turnaround_o     = turn_q;
  assign waiting_o        = wait_q;
  assign sum_turnaround_o = sum_turn_q;
  assign sum_waiting_o    = sum_wait_q;
  assign all_done_o       = all_done_q;

  // Checks
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted transaction did not start work");

  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && finished_o) |-> ran_valid_o)
    else $error("job finished without being served");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ran_valid_o) |-> (!finished_o && (ran_slot_o == '0)))
    else $error("idle result carries job data");

endmodule
